// ===== rtl/c65eu_pkg.sv =====
// ----------------------------------------------------------------------------
// c65eu_pkg
// Operation codes, decoded control word and constants for the execute unit.
// ----------------------------------------------------------------------------
package c65eu_pkg;

	typedef enum logic [6:0] {
		OP_NOP = 7'd0,  OP_LDA = 7'd1,  OP_LDX = 7'd2,  OP_LDY = 7'd3,
		OP_STA = 7'd4,  OP_STX = 7'd5,  OP_STY = 7'd6,  OP_TAX = 7'd7,
		OP_TAY = 7'd8,  OP_TSX = 7'd9,  OP_TXA = 7'd10, OP_TXS = 7'd11,
		OP_TYA = 7'd12, OP_CLC = 7'd13, OP_CLD = 7'd14, OP_CLI = 7'd15,
		OP_CLV = 7'd16, OP_SEC = 7'd17, OP_SED = 7'd18, OP_SEI = 7'd19,
		OP_ADC = 7'd20, OP_SBC = 7'd21, OP_CMP = 7'd22, OP_CPX = 7'd23,
		OP_CPY = 7'd24, OP_AND = 7'd25, OP_ORA = 7'd26, OP_EOR = 7'd27,
		OP_BIT = 7'd28, OP_ASLM = 7'd29, OP_LSRM = 7'd30, OP_ROLM = 7'd31,
		OP_RORM = 7'd32, OP_ASLA = 7'd33, OP_LSRA = 7'd34, OP_ROLA = 7'd35,
		OP_RORA = 7'd36, OP_INC = 7'd37, OP_DEC = 7'd38, OP_INX = 7'd39,
		OP_INY = 7'd40, OP_DEX = 7'd41, OP_DEY = 7'd42, OP_PHA = 7'd43,
		OP_PHP = 7'd44, OP_PLA = 7'd45, OP_PLP = 7'd46, OP_BCC = 7'd47,
		OP_BCS = 7'd48, OP_BEQ = 7'd49, OP_BMI = 7'd50, OP_BNE = 7'd51,
		OP_BPL = 7'd52, OP_BVC = 7'd53, OP_BVS = 7'd54, OP_SLO = 7'd55,
		OP_RLA = 7'd56, OP_SRE = 7'd57, OP_RRA = 7'd58, OP_ISC = 7'd59,
		OP_DCP = 7'd60, OP_LAX = 7'd61, OP_SAX = 7'd62, OP_ANC = 7'd63,
		OP_ALR = 7'd64, OP_ARR = 7'd65, OP_XAA = 7'd66, OP_AXS = 7'd67,
		OP_SHA = 7'd68, OP_SHX = 7'd69, OP_SHY = 7'd70, OP_TAS = 7'd71,
		OP_LAS = 7'd72
	} op_t;

	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] P_RESET  = 8'h24;
	localparam int FL_C = 0;
	localparam int FL_Z = 1;
	localparam int FL_I = 2;
	localparam int FL_D = 3;
	localparam int FL_B = 4;
	localparam int FL_U = 5;
	localparam int FL_V = 6;
	localparam int FL_N = 7;

	// decoded item held in the queue
	typedef struct packed {
		op_t        op;
		logic [7:0] m;
		logic [7:0] hp1;
	} item_t;

	localparam int QDEPTH = 2;

endpackage

// ===== rtl/c65eu_front.sv =====
// ----------------------------------------------------------------------------
// c65eu_front
// Accepts items, maps unused codes to NOP, precomputes addr_high + 1.
// ----------------------------------------------------------------------------
module c65eu_front import c65eu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       stall,
	input  logic [6:0] opcode,
	input  logic [7:0] operand_byte,
	input  logic [7:0] addr_high,
	output logic       q_valid,
	input  logic       q_pop,
	output item_t      q_item
);
	item_t             mem_q [QDEPTH];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;
	logic              push;
	item_t             it;

	always_comb begin
		it.op  = (opcode > 7'(OP_LAS)) ? OP_NOP : op_t'(opcode);
		it.m   = operand_byte;
		it.hp1 = addr_high + 8'd1;
	end

	assign stall   = (cnt_q == 2'(QDEPTH));
	assign push    = valid && !stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= it;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ===== rtl/c65eu_back.sv =====
// ----------------------------------------------------------------------------
// c65eu_back
// Register file and ALU; executes one queued item per cycle, while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module c65eu_back import c65eu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_pop,
	input  item_t      q_item,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] write_data,
	output logic       write_enable,
	output logic [7:0] stack_slot,
	output logic       branch_taken,
	output logic [7:0] acc_out,
	output logic [7:0] index_x_out,
	output logic [7:0] index_y_out,
	output logic [7:0] stack_ptr_out,
	output logic [7:0] status_out
);
	logic [7:0] a_q, x_q, y_q, sp_q, p_q;
	logic [7:0] a_n, x_n, y_n, sp_n, p_n, wd, slot, m, t, sh;
	logic       we, br, ov_q;
	logic [8:0] s;
	logic [7:0] addm;
	logic       do_add, set_nz;
	logic [7:0] nzv;

	assign out_valid = ov_q;
	assign q_pop     = q_valid && (!ov_q || !out_stall);

	always_comb begin
		m = q_item.m;
		a_n = a_q; x_n = x_q; y_n = y_q; sp_n = sp_q; p_n = p_q;
		wd = 8'd0; we = 1'b0; slot = 8'd0; br = 1'b0;
		t = 8'd0; sh = 8'd0; do_add = 1'b0; addm = m;
		set_nz = 1'b0; nzv = 8'd0; s = 9'd0;
		unique case (q_item.op)
			OP_LDA, OP_PLA: begin a_n = m; set_nz = 1'b1; nzv = m; end
			OP_LDX: begin x_n = m; set_nz = 1'b1; nzv = m; end
			OP_LDY: begin y_n = m; set_nz = 1'b1; nzv = m; end
			OP_STA: begin wd = a_q; we = 1'b1; end
			OP_STX: begin wd = x_q; we = 1'b1; end
			OP_STY: begin wd = y_q; we = 1'b1; end
			OP_TAX: begin x_n = a_q; set_nz = 1'b1; nzv = a_q; end
			OP_TAY: begin y_n = a_q; set_nz = 1'b1; nzv = a_q; end
			OP_TSX: begin x_n = sp_q; set_nz = 1'b1; nzv = sp_q; end
			OP_TXA: begin a_n = x_q; set_nz = 1'b1; nzv = x_q; end
			OP_TXS: sp_n = x_q;
			OP_TYA: begin a_n = y_q; set_nz = 1'b1; nzv = y_q; end
			OP_CLC: p_n[FL_C] = 1'b0;
			OP_CLD: p_n[FL_D] = 1'b0;
			OP_CLI: p_n[FL_I] = 1'b0;
			OP_CLV: p_n[FL_V] = 1'b0;
			OP_SEC: p_n[FL_C] = 1'b1;
			OP_SED: p_n[FL_D] = 1'b1;
			OP_SEI: p_n[FL_I] = 1'b1;
			OP_ADC: do_add = 1'b1;
			OP_SBC: begin do_add = 1'b1; addm = ~m; end
			OP_CMP, OP_CPX, OP_CPY: begin
				t = (q_item.op == OP_CMP) ? a_q : (q_item.op == OP_CPX) ? x_q : y_q;
				s = {1'b0, t} - {1'b0, m};
				p_n[FL_C] = ~s[8]; set_nz = 1'b1; nzv = s[7:0];
			end
			OP_AND, OP_XAA: begin a_n = a_q & m; set_nz = 1'b1; nzv = a_n; end
			OP_ORA: begin a_n = a_q | m; set_nz = 1'b1; nzv = a_n; end
			OP_EOR: begin a_n = a_q ^ m; set_nz = 1'b1; nzv = a_n; end
			OP_BIT: begin
				p_n[FL_Z] = ((a_q & m) == 8'd0);
				p_n[FL_V] = m[6]; p_n[FL_N] = m[7];
			end
			OP_ASLM, OP_ROLM, OP_SLO, OP_RLA: begin
				sh = {m[6:0], (q_item.op == OP_ROLM || q_item.op == OP_RLA) & p_q[FL_C]};
				p_n[FL_C] = m[7]; wd = sh; we = 1'b1;
				if (q_item.op == OP_SLO) a_n = a_q | sh;
				else if (q_item.op == OP_RLA) a_n = a_q & sh;
				set_nz = 1'b1;
				nzv = (q_item.op == OP_SLO || q_item.op == OP_RLA) ? a_n : sh;
			end
			OP_LSRM, OP_RORM, OP_SRE, OP_RRA: begin
				sh = {(q_item.op == OP_RORM || q_item.op == OP_RRA) & p_q[FL_C], m[7:1]};
				p_n[FL_C] = m[0]; wd = sh; we = 1'b1;
				if (q_item.op == OP_SRE) begin
					a_n = a_q ^ sh; set_nz = 1'b1; nzv = a_n;
				end else if (q_item.op == OP_RRA) begin
					do_add = 1'b1; addm = sh;
				end else begin
					set_nz = 1'b1; nzv = sh;
				end
			end
			OP_ASLA, OP_ROLA: begin
				sh = {a_q[6:0], (q_item.op == OP_ROLA) & p_q[FL_C]};
				p_n[FL_C] = a_q[7]; a_n = sh; set_nz = 1'b1; nzv = sh;
			end
			OP_LSRA, OP_RORA, OP_ALR: begin
				t = (q_item.op == OP_ALR) ? (a_q & m) : a_q;
				sh = {(q_item.op == OP_RORA) & p_q[FL_C], t[7:1]};
				p_n[FL_C] = t[0]; a_n = sh; set_nz = 1'b1; nzv = sh;
			end
			OP_INC, OP_ISC: begin
				wd = m + 8'd1; we = 1'b1;
				if (q_item.op == OP_ISC) begin do_add = 1'b1; addm = ~wd; end
				else begin set_nz = 1'b1; nzv = wd; end
			end
			OP_DEC, OP_DCP: begin
				wd = m - 8'd1; we = 1'b1;
				if (q_item.op == OP_DCP) begin
					s = {1'b0, a_q} - {1'b0, wd};
					p_n[FL_C] = ~s[8]; set_nz = 1'b1; nzv = s[7:0];
				end else begin set_nz = 1'b1; nzv = wd; end
			end
			OP_INX: begin x_n = x_q + 8'd1; set_nz = 1'b1; nzv = x_n; end
			OP_INY: begin y_n = y_q + 8'd1; set_nz = 1'b1; nzv = y_n; end
			OP_DEX: begin x_n = x_q - 8'd1; set_nz = 1'b1; nzv = x_n; end
			OP_DEY: begin y_n = y_q - 8'd1; set_nz = 1'b1; nzv = y_n; end
			OP_PHA, OP_PHP: begin
				wd = (q_item.op == OP_PHA) ? a_q : (p_q | 8'h30);
				we = 1'b1; slot = sp_q; sp_n = sp_q - 8'd1;
			end
			OP_PLP: begin
				sp_n = sp_q + 8'd1; p_n = (m | 8'h20) & 8'hEF;
			end
			OP_BCC: br = ~p_q[FL_C];
			OP_BCS: br = p_q[FL_C];
			OP_BEQ: br = p_q[FL_Z];
			OP_BMI: br = p_q[FL_N];
			OP_BNE: br = ~p_q[FL_Z];
			OP_BPL: br = ~p_q[FL_N];
			OP_BVC: br = ~p_q[FL_V];
			OP_BVS: br = p_q[FL_V];
			OP_LAX: begin a_n = m; x_n = m; set_nz = 1'b1; nzv = m; end
			OP_SAX: begin wd = a_q & x_q; we = 1'b1; end
			OP_ANC: begin
				a_n = a_q & m; set_nz = 1'b1; nzv = a_n; p_n[FL_C] = a_n[7];
			end
			OP_ARR: begin
				t = {p_q[FL_C], a_q[7:1] & m[7:1]};
				a_n = t; set_nz = 1'b1; nzv = t;
				p_n[FL_C] = t[6]; p_n[FL_V] = t[6] ^ t[5];
			end
			OP_AXS: begin
				t = a_q & x_q; s = {1'b0, t} - {1'b0, m};
				p_n[FL_C] = ~s[8]; x_n = s[7:0]; set_nz = 1'b1; nzv = s[7:0];
			end
			OP_SHA: begin wd = a_q & x_q & q_item.hp1; we = 1'b1; end
			OP_SHX: begin wd = x_q & q_item.hp1; we = 1'b1; end
			OP_SHY: begin wd = y_q & q_item.hp1; we = 1'b1; end
			OP_TAS: begin
				sp_n = a_q & x_q; wd = a_q & x_q & q_item.hp1; we = 1'b1;
			end
			OP_LAS: begin
				t = m & sp_q; a_n = t; x_n = t; sp_n = t; set_nz = 1'b1; nzv = t;
			end
			default: ;
		endcase
		if (q_item.op == OP_PLA) begin
			sp_n = sp_q + 8'd1; slot = sp_n;
		end
		if (q_item.op == OP_PLP) slot = sp_n;
		// carry in is the one left by the shift for RRA
		if (do_add) begin
			s = {1'b0, a_q} + {1'b0, addm} + {8'd0, p_n[FL_C]};
			p_n[FL_C] = s[8];
			p_n[FL_V] = (a_q[7] ^ s[7]) & (addm[7] ^ s[7]);
			a_n = s[7:0]; set_nz = 1'b1; nzv = s[7:0];
		end
		if (set_nz) begin
			p_n[FL_Z] = (nzv == 8'd0); p_n[FL_N] = nzv[7];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			write_data <= wd; write_enable <= we; stack_slot <= slot;
			branch_taken <= br;
		end
	end

	assign acc_out = a_q;
	assign index_x_out = x_q;
	assign index_y_out = y_q;
	assign stack_ptr_out = sp_q;
	assign status_out = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0; sp_q <= SP_RESET; p_q <= P_RESET;
			ov_q <= 1'b0;
		end else begin
			if (q_pop) begin
				a_q <= a_n; x_q <= x_n; y_q <= y_n; sp_q <= sp_n; p_q <= p_n;
				ov_q <= 1'b1;
			end else if (!out_stall) ov_q <= 1'b0;
		end
	end
endmodule

// ===== rtl/cpu_6502_execute_unit.sv =====
// ----------------------------------------------------------------------------
// cpu_6502_execute_unit
// 6502 execute unit: A, X, Y, SP, P with ALU incl. undocumented operations.
// ----------------------------------------------------------------------------
// One item per cycle sustained while the output is not stalled. An item is written
// into the queue on acceptance and from there into the back end's output register;
// the two-entry queue between the front and the ALU back end absorbs output stalls.
// Register outputs are held in the architectural registers and shown with the item.
module cpu_6502_execute_unit import c65eu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [6:0] opcode,
	input  logic [7:0] operand_byte,
	input  logic [7:0] addr_high,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] write_data,
	output logic       write_enable,
	output logic [7:0] stack_slot,
	output logic       branch_taken,
	output logic [7:0] acc_out,
	output logic [7:0] index_x_out,
	output logic [7:0] index_y_out,
	output logic [7:0] stack_ptr_out,
	output logic [7:0] status_out
);
	logic  q_valid, q_pop;
	item_t q_item;

	c65eu_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .opcode,
		.operand_byte, .addr_high, .q_valid, .q_pop, .q_item
	);

	c65eu_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item, .out_valid, .out_stall,
		.write_data, .write_enable, .stack_slot, .branch_taken, .acc_out,
		.index_x_out, .index_y_out, .stack_ptr_out, .status_out
	);
endmodule

// ===== rtl/c65eu_checker.sv =====
// ----------------------------------------------------------------------------
// c65eu_checker
// Port-level checks on the execute unit.
// ----------------------------------------------------------------------------
module c65eu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       write_enable,
	input logic [7:0] write_data,
	input logic [7:0] status_out,
	input logic [7:0] stack_slot,
	input logic       branch_taken
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(write_data))
		else $error("stalled item changed");
	a_wd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> write_data == 8'd0)
		else $error("data without write");
	a_u: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status_out[5])
		else $error("unused flag clear");
	a_br: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && branch_taken |-> !write_enable && stack_slot == 8'd0)
		else $error("branch with side effect");
endmodule

bind cpu_6502_execute_unit c65eu_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .write_enable, .write_data,
	.status_out, .stack_slot, .branch_taken
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// 6502 execute unit testbench
// Drives operation items through the valid/stall handshake with random
// idling on both sides, predicts every result with a local register model
// and compares each output field in order.
// ----------------------------------------------------------------------------
module testbench;
	import c65eu_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		logic [7:0] wdata;
		logic       wen;
		logic [7:0] slot;
		logic       taken;
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic [7:0] p;
	} cpu_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [6:0] opcode;
	logic [7:0] operand_byte;
	logic [7:0] addr_high;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] write_data;
	logic       write_enable;
	logic [7:0] stack_slot;
	logic       branch_taken;
	logic [7:0] acc_out;
	logic [7:0] index_x_out;
	logic [7:0] index_y_out;
	logic [7:0] stack_ptr_out;
	logic [7:0] status_out;

	// predicted architectural state
	logic [7:0] m_a, m_x, m_y, m_sp, m_p;
	cpu_result_t expected_q[$];
	int  errors;
	int  idle_cycles;
	int  send_idle_pct;
	int  stall_pct;

	cpu_6502_execute_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .operand_byte(operand_byte), .addr_high(addr_high),
		.out_valid(out_valid), .out_stall(out_stall),
		.write_data(write_data), .write_enable(write_enable),
		.stack_slot(stack_slot), .branch_taken(branch_taken),
		.acc_out(acc_out), .index_x_out(index_x_out), .index_y_out(index_y_out),
		.stack_ptr_out(stack_ptr_out), .status_out(status_out)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void set_nz(input logic [7:0] v);
		m_p[FL_Z] = (v == 8'h00);
		m_p[FL_N] = v[7];
	endfunction

	function automatic void adc_acc(input logic [7:0] v);
		logic [8:0] s;
		s = {1'b0, m_a} + {1'b0, v} + {8'd0, m_p[FL_C]};
		m_p[FL_C] = s[8];
		m_p[FL_V] = (m_a[7] ^ s[7]) & (v[7] ^ s[7]);
		m_a = s[7:0];
		set_nz(m_a);
	endfunction

	function automatic void cmp_reg(input logic [7:0] r, input logic [7:0] v);
		m_p[FL_C] = (r >= v);
		set_nz(r - v);
	endfunction

	function automatic logic [7:0] shift_left(input logic [7:0] v, input logic rot);
		logic cin;
		cin = rot & m_p[FL_C];
		m_p[FL_C] = v[7];
		v = {v[6:0], cin};
		set_nz(v);
		return v;
	endfunction

	function automatic logic [7:0] shift_right(input logic [7:0] v, input logic rot);
		logic cin;
		cin = rot & m_p[FL_C];
		m_p[FL_C] = v[0];
		v = {cin, v[7:1]};
		set_nz(v);
		return v;
	endfunction

	function automatic cpu_result_t execute_op(input logic [6:0] code, input logic [7:0] m,
			input logic [7:0] ah);
		cpu_result_t r;
		logic [7:0] hp1, p0, t;
		hp1 = ah + 8'd1;
		p0 = m_p;
		r.wdata = 8'h00; r.wen = 1'b0; r.slot = 8'h00; r.taken = 1'b0;
		case (code)
			OP_LDA: begin m_a = m; set_nz(m_a); end
			OP_LDX: begin m_x = m; set_nz(m_x); end
			OP_LDY: begin m_y = m; set_nz(m_y); end
			OP_STA: begin r.wdata = m_a; r.wen = 1'b1; end
			OP_STX: begin r.wdata = m_x; r.wen = 1'b1; end
			OP_STY: begin r.wdata = m_y; r.wen = 1'b1; end
			OP_TAX: begin m_x = m_a; set_nz(m_x); end
			OP_TAY: begin m_y = m_a; set_nz(m_y); end
			OP_TSX: begin m_x = m_sp; set_nz(m_x); end
			OP_TXA: begin m_a = m_x; set_nz(m_a); end
			OP_TXS: m_sp = m_x;
			OP_TYA: begin m_a = m_y; set_nz(m_a); end
			OP_CLC: m_p[FL_C] = 1'b0;
			OP_CLD: m_p[FL_D] = 1'b0;
			OP_CLI: m_p[FL_I] = 1'b0;
			OP_CLV: m_p[FL_V] = 1'b0;
			OP_SEC: m_p[FL_C] = 1'b1;
			OP_SED: m_p[FL_D] = 1'b1;
			OP_SEI: m_p[FL_I] = 1'b1;
			OP_ADC: adc_acc(m);
			OP_SBC: adc_acc(~m);
			OP_CMP: cmp_reg(m_a, m);
			OP_CPX: cmp_reg(m_x, m);
			OP_CPY: cmp_reg(m_y, m);
			OP_AND: begin m_a = m_a & m; set_nz(m_a); end
			OP_ORA: begin m_a = m_a | m; set_nz(m_a); end
			OP_EOR: begin m_a = m_a ^ m; set_nz(m_a); end
			OP_BIT: begin
				m_p[FL_Z] = ((m_a & m) == 8'h00);
				m_p[FL_V] = m[6];
				m_p[FL_N] = m[7];
			end
			OP_ASLM: begin r.wdata = shift_left(m, 1'b0); r.wen = 1'b1; end
			OP_LSRM: begin r.wdata = shift_right(m, 1'b0); r.wen = 1'b1; end
			OP_ROLM: begin r.wdata = shift_left(m, 1'b1); r.wen = 1'b1; end
			OP_RORM: begin r.wdata = shift_right(m, 1'b1); r.wen = 1'b1; end
			OP_ASLA: m_a = shift_left(m_a, 1'b0);
			OP_LSRA: m_a = shift_right(m_a, 1'b0);
			OP_ROLA: m_a = shift_left(m_a, 1'b1);
			OP_RORA: m_a = shift_right(m_a, 1'b1);
			OP_INC: begin r.wdata = m + 8'd1; r.wen = 1'b1; set_nz(r.wdata); end
			OP_DEC: begin r.wdata = m - 8'd1; r.wen = 1'b1; set_nz(r.wdata); end
			OP_INX: begin m_x = m_x + 8'd1; set_nz(m_x); end
			OP_INY: begin m_y = m_y + 8'd1; set_nz(m_y); end
			OP_DEX: begin m_x = m_x - 8'd1; set_nz(m_x); end
			OP_DEY: begin m_y = m_y - 8'd1; set_nz(m_y); end
			OP_PHA, OP_PHP: begin
				r.wdata = (code == OP_PHA) ? m_a : (p0 | 8'h30);
				r.wen = 1'b1;
				r.slot = m_sp;
				m_sp = m_sp - 8'd1;
			end
			OP_PLA: begin
				m_sp = m_sp + 8'd1; r.slot = m_sp;
				m_a = m; set_nz(m_a);
			end
			OP_PLP: begin
				m_sp = m_sp + 8'd1; r.slot = m_sp;
				m_p = (m | 8'h20) & 8'hEF;
			end
			OP_BCC: r.taken = ~p0[FL_C];
			OP_BCS: r.taken = p0[FL_C];
			OP_BEQ: r.taken = p0[FL_Z];
			OP_BMI: r.taken = p0[FL_N];
			OP_BNE: r.taken = ~p0[FL_Z];
			OP_BPL: r.taken = ~p0[FL_N];
			OP_BVC: r.taken = ~p0[FL_V];
			OP_BVS: r.taken = p0[FL_V];
			OP_SLO: begin
				r.wdata = shift_left(m, 1'b0); r.wen = 1'b1;
				m_a = m_a | r.wdata; set_nz(m_a);
			end
			OP_RLA: begin
				r.wdata = shift_left(m, 1'b1); r.wen = 1'b1;
				m_a = m_a & r.wdata; set_nz(m_a);
			end
			OP_SRE: begin
				r.wdata = shift_right(m, 1'b0); r.wen = 1'b1;
				m_a = m_a ^ r.wdata; set_nz(m_a);
			end
			OP_RRA: begin
				r.wdata = shift_right(m, 1'b1); r.wen = 1'b1;
				adc_acc(r.wdata);
			end
			OP_ISC: begin r.wdata = m + 8'd1; r.wen = 1'b1; adc_acc(~r.wdata); end
			OP_DCP: begin r.wdata = m - 8'd1; r.wen = 1'b1; cmp_reg(m_a, r.wdata); end
			OP_LAX: begin m_a = m; m_x = m; set_nz(m); end
			OP_SAX: begin r.wdata = m_a & m_x; r.wen = 1'b1; end
			OP_ANC: begin m_a = m_a & m; set_nz(m_a); m_p[FL_C] = m_a[7]; end
			OP_ALR: m_a = shift_right(m_a & m, 1'b0);
			OP_ARR: begin
				t = {p0[FL_C], m_a[7:1] & m[7:1]};
				m_a = t; set_nz(t);
				m_p[FL_C] = t[6];
				m_p[FL_V] = t[6] ^ t[5];
			end
			OP_XAA: begin m_a = m_a & m; set_nz(m_a); end
			OP_AXS: begin
				t = m_a & m_x;
				m_p[FL_C] = (t >= m);
				m_x = t - m; set_nz(m_x);
			end
			OP_SHA: begin r.wdata = m_a & m_x & hp1; r.wen = 1'b1; end
			OP_SHX: begin r.wdata = m_x & hp1; r.wen = 1'b1; end
			OP_SHY: begin r.wdata = m_y & hp1; r.wen = 1'b1; end
			OP_TAS: begin
				m_sp = m_a & m_x;
				r.wdata = m_a & m_x & hp1; r.wen = 1'b1;
			end
			OP_LAS: begin
				t = m & m_sp;
				m_a = t; m_x = t; m_sp = t; set_nz(t);
			end
			default: ;
		endcase
		r.a = m_a; r.x = m_x; r.y = m_y; r.sp = m_sp; r.p = m_p;
		return r;
	endfunction

	// valid stays up after an accepted item; it drops only for an idle cycle
	// or once the test sequence is over
	task automatic send_op(input logic [6:0] code, input logic [7:0] m, input logic [7:0] ah);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= code;
		operand_byte <= m;
		addr_high <= ah;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_q.push_back(execute_op(code, m, ah));
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cpu_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (write_data !== e.wdata) begin
					$error("write_data exp %h got %h", e.wdata, write_data); errors++;
				end
				if (write_enable !== e.wen) begin
					$error("write_enable exp %b got %b", e.wen, write_enable); errors++;
				end
				if (stack_slot !== e.slot) begin
					$error("stack_slot exp %h got %h", e.slot, stack_slot); errors++;
				end
				if (branch_taken !== e.taken) begin
					$error("branch_taken exp %b got %b", e.taken, branch_taken); errors++;
				end
				if (acc_out !== e.a) begin
					$error("acc_out exp %h got %h", e.a, acc_out); errors++;
				end
				if (index_x_out !== e.x) begin
					$error("index_x_out exp %h got %h", e.x, index_x_out); errors++;
				end
				if (index_y_out !== e.y) begin
					$error("index_y_out exp %h got %h", e.y, index_y_out); errors++;
				end
				if (stack_ptr_out !== e.sp) begin
					$error("stack_ptr_out exp %h got %h", e.sp, stack_ptr_out); errors++;
				end
				if (status_out !== e.p) begin
					$error("status_out exp %h got %h", e.p, status_out); errors++;
				end
			end
		end
	end

	// watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		int i;
		// extremes of operand and every operation, with flags set both ways
		send_op(OP_LDA, 8'h00, 8'h00);
		send_op(OP_LDX, 8'hFF, 8'hFF);
		send_op(OP_SEC, 8'h00, 8'h00);
		send_op(OP_ADC, 8'hFF, 8'h00);
		send_op(OP_ARR, 8'hFF, 8'h00);
		send_op(OP_LDA, 8'h7F, 8'h00);
		send_op(OP_ADC, 8'h01, 8'h00);
		send_op(OP_PHP, 8'h00, 8'h00);
		send_op(OP_PLP, 8'hFF, 8'h00);
		send_op(OP_TAS, 8'h00, 8'hFF);
		send_op(OP_SHA, 8'h00, 8'hFE);
		send_op(OP_LAS, 8'hFF, 8'h00);
		send_op(7'd127, 8'hAA, 8'h55);
		for (i = 0; i <= 80; i++)
			send_op(i[6:0], 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic test_stack_wrap();
		int i;
		send_op(OP_LDX, 8'h01, 8'h00);
		send_op(OP_TXS, 8'h00, 8'h00);
		for (i = 0; i < 3; i++) send_op(OP_PHA, 8'h00, 8'h00);
		for (i = 0; i < 4; i++) send_op(OP_PLA, 8'($urandom_range(255)), 8'h00);
		send_op(OP_PLP, 8'($urandom_range(255)), 8'h00);
	endtask

	task automatic test_random(input int count);
		int i;
		logic [6:0] code;
		for (i = 0; i < count; i++) begin
			code = ($urandom_range(19) == 0) ? 7'($urandom_range(127)) :
				7'($urandom_range(72));
			send_op(code, 8'($urandom_range(255)), 8'($urandom_range(255)));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	initial begin
		errors = 0; idle_cycles = 0;
		send_idle_pct = 0; stall_pct = 0;
		m_a = 8'h00; m_x = 8'h00; m_y = 8'h00; m_sp = SP_RESET; m_p = P_RESET;
		arst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0;
		opcode = '0; operand_byte = '0; addr_high = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_stack_wrap();
		test_random(300);
		send_idle_pct = 72; stall_pct = 0;
		test_random(300);
		send_idle_pct = 0; stall_pct = 72;
		test_random(300);
		send_idle_pct = 29; stall_pct = 29;
		test_random(300);
		send_idle_pct = 0; stall_pct = 0;
		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
